### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the checker module of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_CLK_NORST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/isc_pkg.sv
// ----------------------------------------------------------------------------
// isc_pkg
// Types, codes and constants of the still-window IMU calibrator.
// ----------------------------------------------------------------------------
package isc_pkg;

  localparam int unsigned MAX_WINDOW_LOG2 = 12;
  localparam int unsigned MIN_WINDOW_LOG2 = 4;
  localparam int unsigned K_W             = 5;
  localparam int unsigned WLOG_W          = 4;
  localparam int unsigned SAMPLE_W        = 16;
  localparam int unsigned SQM_W           = 2 * SAMPLE_W - 1;
  localparam int unsigned LIMIT_W         = 30;
  localparam int unsigned ANGLE_W         = 15;
  localparam int unsigned CFG_W           = 30;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned OUT_DEPTH       = 8;
  localparam int unsigned OUT_AW          = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W       = $clog2(OUT_DEPTH + 1);

  localparam logic [WLOG_W-1:0]  RST_WINDOW_LOG2  = 4'd10;
  localparam logic [LIMIT_W-1:0] RST_GYRO_LIMIT   = 30'd5625;
  localparam logic [LIMIT_W-1:0] RST_ACCEL_LIMIT  = 30'd697225;
  localparam logic [ANGLE_W-1:0] RST_ORIENT_LIMIT = 15'd8354;
  localparam logic [ANGLE_W-1:0] RST_VERIFY_LIMIT = 15'd8;

  localparam logic [1:0] AXIS_Z = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  typedef enum logic [2:0] {
    OP_SAMPLE       = 3'd0,
    OP_START_BIAS   = 3'd1,
    OP_START_POS    = 3'd2,
    OP_START_VERIFY = 3'd3,
    OP_FIT          = 3'd4
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LOG2  = 3'd0,
    CFG_GYRO_LIMIT   = 3'd1,
    CFG_ACCEL_LIMIT  = 3'd2,
    CFG_ORIENT_LIMIT = 3'd3,
    CFG_VERIFY_LIMIT = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_PASS           = 3'd0,
    ST_MOVED          = 3'd1,
    ST_ORIENT         = 3'd2,
    ST_NO_BIAS        = 3'd3,
    ST_VERIFY_HIGH    = 3'd4,
    ST_FIT_INCOMPLETE = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_BIAS   = 2'd1,
    MODE_POS    = 2'd2,
    MODE_VERIFY = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    EV_BIAS_START   = 2'd0,
    EV_VERIFY_START = 2'd1,
    EV_FIT          = 2'd2,
    EV_WINDOW_END   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t          kind;
    mode_t          mode;
    logic [1:0]     axis;
    logic           sign;
    logic [K_W-1:0] k;
  } ev_ctrl_t;

  typedef struct packed {
    status_t       status;
    logic [15:0]   x;
    logic [15:0]   y;
    logic [15:0]   z;
    logic [15:0]   span;
    logic [2:0]    flags;
  } result_t;

  function automatic logic [K_W-1:0] clamp_k(input logic [WLOG_W-1:0] wl,
                                             input int unsigned max_k);
    logic [K_W-1:0] k;
    k = K_W'(wl);
    if (wl < WLOG_W'(MIN_WINDOW_LOG2)) begin
      k = K_W'(MIN_WINDOW_LOG2);
    end else if (K_W'(wl) > K_W'(max_k)) begin
      k = K_W'(max_k);
    end
    return k;
  endfunction

endpackage

### rtl/imu_still_window_calibrator_core.sv
// ----------------------------------------------------------------------------
// imu_still_window_calibrator_core
// Gyro bias, six-position accel and gyro verify calibration over still windows.
// ----------------------------------------------------------------------------
// One item is taken every clock cycle while in_stall is low. The item that
// causes a result passes the input register, accumulate stage, mean and
// square stage, then the decision stage writes an eight-entry result
// queue. The input stalls only when the queue entries in use plus the items
// in the three stages reach eight, so a stalled output lets several more
// items in before the input holds.
module imu_still_window_calibrator_core #(
  parameter int unsigned MAX_WINDOW_LOG2 = isc_pkg::MAX_WINDOW_LOG2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      opcode,
  input  logic [1:0]                      axis_sel,
  input  logic                            sign_up,
  input  logic signed [15:0]              accel_x,
  input  logic signed [15:0]              accel_y,
  input  logic signed [15:0]              accel_z,
  input  logic signed [15:0]              gyro_x,
  input  logic signed [15:0]              gyro_y,
  input  logic signed [15:0]              gyro_z,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      status,
  output logic signed [15:0]              out_x,
  output logic signed [15:0]              out_y,
  output logic signed [15:0]              out_z,
  output logic [15:0]                     span,
  output logic [2:0]                      high_flags,
  input  logic                            cfg_we,
  input  logic [isc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [isc_pkg::CFG_W-1:0]       cfg_data
);
  import isc_pkg::*;

  localparam int unsigned SUM_W = SAMPLE_W + MAX_WINDOW_LOG2 + 1;
  localparam int unsigned SQ_W  = 2 * SAMPLE_W - 1 + MAX_WINDOW_LOG2;
  localparam int unsigned OCC_W = OUT_CNT_W + 1;

  logic [WLOG_W-1:0]      window_log2;
  logic [LIMIT_W-1:0]     gyro_var_limit;
  logic [LIMIT_W-1:0]     accel_var_limit;
  logic [ANGLE_W-1:0]     orient_limit;
  logic [ANGLE_W-1:0]     verify_limit;

  logic                   accept;
  logic [5:0][15:0]       samp;
  logic                   p0_valid;
  logic                   ev_valid;
  ev_ctrl_t               ev_ctrl;
  logic [5:0][SUM_W-1:0]  ev_sum;
  logic [5:0][SQ_W-1:0]   ev_sq;
  logic                   st_valid;
  ev_ctrl_t               st_ctrl;
  logic [5:0][15:0]       st_mean;
  logic [5:0][SQM_W-1:0]  st_sqm;
  logic [5:0][SQM_W-1:0]  st_msq;
  logic                   res_valid;
  result_t                res;
  result_t                head;
  logic [OUT_CNT_W-1:0]   fifo_count;
  logic [OCC_W-1:0]       occupancy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_log2     <= RST_WINDOW_LOG2;
      gyro_var_limit  <= RST_GYRO_LIMIT;
      accel_var_limit <= RST_ACCEL_LIMIT;
      orient_limit    <= RST_ORIENT_LIMIT;
      verify_limit    <= RST_VERIFY_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WINDOW_LOG2:  window_log2     <= cfg_data[WLOG_W-1:0];
        CFG_GYRO_LIMIT:   gyro_var_limit  <= cfg_data[LIMIT_W-1:0];
        CFG_ACCEL_LIMIT:  accel_var_limit <= cfg_data[LIMIT_W-1:0];
        CFG_ORIENT_LIMIT: orient_limit    <= cfg_data[ANGLE_W-1:0];
        CFG_VERIFY_LIMIT: verify_limit    <= cfg_data[ANGLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // credit for the result queue
  assign occupancy = {1'b0, fifo_count} + OCC_W'(p0_valid) + OCC_W'(ev_valid) +
                     OCC_W'(st_valid);
  assign in_stall  = occupancy >= OCC_W'(OUT_DEPTH);
  assign accept    = in_valid && !in_stall;
  assign samp      = {gyro_z, gyro_y, gyro_x, accel_z, accel_y, accel_x};

  isc_accum #(
    .MAX_WINDOW_LOG2 (MAX_WINDOW_LOG2)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .opcode      (opcode),
    .axis_sel    (axis_sel),
    .sign_up     (sign_up),
    .samp        (samp),
    .window_log2 (window_log2),
    .p0_valid    (p0_valid),
    .ev_valid    (ev_valid),
    .ev_ctrl     (ev_ctrl),
    .ev_sum      (ev_sum),
    .ev_sq       (ev_sq)
  );

  isc_stats #(
    .MAX_WINDOW_LOG2 (MAX_WINDOW_LOG2)
  ) u_stats (
    .clk      (clk),
    .rst      (rst),
    .ev_valid (ev_valid),
    .ev_ctrl  (ev_ctrl),
    .ev_sum   (ev_sum),
    .ev_sq    (ev_sq),
    .st_valid (st_valid),
    .st_ctrl  (st_ctrl),
    .st_mean  (st_mean),
    .st_sqm   (st_sqm),
    .st_msq   (st_msq)
  );

  isc_decide u_decide (
    .clk             (clk),
    .rst             (rst),
    .st_valid        (st_valid),
    .st_ctrl         (st_ctrl),
    .st_mean         (st_mean),
    .st_sqm          (st_sqm),
    .st_msq          (st_msq),
    .gyro_var_limit  (gyro_var_limit),
    .accel_var_limit (accel_var_limit),
    .orient_limit    (orient_limit),
    .verify_limit    (verify_limit),
    .res_valid       (res_valid),
    .res             (res)
  );

  isc_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (res_valid),
    .wr_data  (res),
    .rd_en    (out_valid && !out_stall),
    .rd_valid (out_valid),
    .rd_data  (head),
    .count    (fifo_count)
  );

  assign status     = head.status;
  assign out_x      = head.x;
  assign out_y      = head.y;
  assign out_z      = head.z;
  assign span       = head.span;
  assign high_flags = head.flags;

endmodule

### rtl/isc_accum.sv
// ----------------------------------------------------------------------------
// isc_accum
// Input register, run control and per-channel sum / sum-of-squares window.
// ----------------------------------------------------------------------------
module isc_accum #(
  parameter int unsigned MAX_WINDOW_LOG2 = isc_pkg::MAX_WINDOW_LOG2,
  localparam int unsigned SUM_W = isc_pkg::SAMPLE_W + MAX_WINDOW_LOG2 + 1,
  localparam int unsigned SQ_W  = 2 * isc_pkg::SAMPLE_W - 1 + MAX_WINDOW_LOG2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [2:0]                    opcode,
  input  logic [1:0]                    axis_sel,
  input  logic                          sign_up,
  input  logic [5:0][15:0]              samp,
  input  logic [isc_pkg::WLOG_W-1:0]    window_log2,
  output logic                          p0_valid,
  output logic                          ev_valid,
  output isc_pkg::ev_ctrl_t             ev_ctrl,
  output logic [5:0][SUM_W-1:0]         ev_sum,
  output logic [5:0][SQ_W-1:0]          ev_sq
);
  import isc_pkg::*;

  localparam int unsigned CNT_W = MAX_WINDOW_LOG2 + 1;

  opcode_t                 p0_op;
  logic [1:0]              p0_axis;
  logic                    p0_sign;
  logic [5:0][15:0]        p0_samp;

  mode_t                   run_mode;
  mode_t                   mode_next;
  logic [1:0]              pend_axis;
  logic                    pend_sign;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_inc;
  logic [CNT_W-1:0]        win_len;
  logic [K_W-1:0]          k;
  logic signed [SUM_W-1:0] sum     [6];
  logic [SQ_W-1:0]         sq      [6];
  logic signed [SUM_W-1:0] sum_add [6];
  logic [SQ_W-1:0]         sq_add  [6];
  logic signed [31:0]      prod    [6];
  logic                    is_start;
  logic                    is_sample;
  logic                    win_done;
  logic                    ev_fire;
  ev_ctrl_t                ev_ctrl_next;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else begin
      p0_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p0_op   <= opcode_t'(opcode);
      p0_axis <= (axis_sel == AXIS_NONE) ? AXIS_Z : axis_sel;
      p0_sign <= sign_up;
      p0_samp <= samp;
    end
  end

  assign k         = clamp_k(window_log2, MAX_WINDOW_LOG2);
  assign is_start  = p0_valid && (p0_op == OP_START_BIAS || p0_op == OP_START_POS ||
                                  p0_op == OP_START_VERIFY);
  assign is_sample = p0_valid && (p0_op == OP_SAMPLE) && (run_mode != MODE_IDLE);
  assign count_inc = count + CNT_W'(1);
  assign win_len   = CNT_W'(1) << k;
  assign win_done  = is_sample && (count_inc >= win_len);

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      prod[i]    = $signed(p0_samp[i]) * $signed(p0_samp[i]);
      sum_add[i] = sum[i] + {{(SUM_W-16){p0_samp[i][15]}}, p0_samp[i]};
      sq_add[i]  = sq[i] + {{(SQ_W-32){1'b0}}, prod[i]};
    end
  end

  // run mode next state
  always_comb begin
    mode_next = run_mode;
    if (p0_valid) begin
      unique case (p0_op)
        OP_START_BIAS:   mode_next = MODE_BIAS;
        OP_START_POS:    mode_next = MODE_POS;
        OP_START_VERIFY: mode_next = MODE_VERIFY;
        OP_SAMPLE: begin
          if (win_done) begin
            mode_next = MODE_IDLE;
          end
        end
        default:         mode_next = run_mode;
      endcase
    end
  end

  // event to the statistics stage
  always_comb begin
    ev_fire           = win_done;
    ev_ctrl_next.kind = EV_WINDOW_END;
    ev_ctrl_next.mode = run_mode;
    ev_ctrl_next.axis = pend_axis;
    ev_ctrl_next.sign = pend_sign;
    ev_ctrl_next.k    = k;
    if (p0_valid) begin
      unique case (p0_op)
        OP_START_BIAS: begin
          ev_fire           = 1'b1;
          ev_ctrl_next.kind = EV_BIAS_START;
        end
        OP_START_VERIFY: begin
          ev_fire           = 1'b1;
          ev_ctrl_next.kind = EV_VERIFY_START;
        end
        OP_FIT: begin
          ev_fire           = 1'b1;
          ev_ctrl_next.kind = EV_FIT;
          ev_ctrl_next.axis = p0_axis;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode <= MODE_IDLE;
      count    <= '0;
      ev_valid <= 1'b0;
    end else begin
      run_mode <= mode_next;
      ev_valid <= ev_fire;
      if (is_start || win_done) begin
        count <= '0;
      end else if (is_sample) begin
        count <= count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      if (is_start || win_done) begin
        sum[i] <= '0;
        sq[i]  <= '0;
      end else if (is_sample) begin
        sum[i] <= sum_add[i];
        sq[i]  <= sq_add[i];
      end
    end
    if (is_start) begin
      pend_axis <= p0_axis;
      pend_sign <= p0_sign;
    end
    if (ev_fire) begin
      ev_ctrl <= ev_ctrl_next;
      for (int i = 0; i < 6; i++) begin
        ev_sum[i] <= sum_add[i];
        ev_sq[i]  <= sq_add[i];
      end
    end
  end

endmodule

### rtl/isc_stats.sv
// ----------------------------------------------------------------------------
// isc_stats
// Window means, mean of squares and squared means for all six channels.
// ----------------------------------------------------------------------------
module isc_stats #(
  parameter int unsigned MAX_WINDOW_LOG2 = isc_pkg::MAX_WINDOW_LOG2,
  localparam int unsigned SUM_W = isc_pkg::SAMPLE_W + MAX_WINDOW_LOG2 + 1,
  localparam int unsigned SQ_W  = 2 * isc_pkg::SAMPLE_W - 1 + MAX_WINDOW_LOG2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            ev_valid,
  input  isc_pkg::ev_ctrl_t               ev_ctrl,
  input  logic [5:0][SUM_W-1:0]           ev_sum,
  input  logic [5:0][SQ_W-1:0]            ev_sq,
  output logic                            st_valid,
  output isc_pkg::ev_ctrl_t               st_ctrl,
  output logic [5:0][15:0]                st_mean,
  output logic [5:0][isc_pkg::SQM_W-1:0]  st_sqm,
  output logic [5:0][isc_pkg::SQM_W-1:0]  st_msq
);
  import isc_pkg::*;

  logic signed [SUM_W-1:0] mean_full [6];
  logic [SQ_W-1:0]         sqm_full  [6];
  logic signed [15:0]      mean      [6];
  logic signed [31:0]      msq       [6];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      mean_full[i] = $signed(ev_sum[i]) >>> ev_ctrl.k;
      mean[i]      = mean_full[i][15:0];
      msq[i]       = mean[i] * mean[i];
      sqm_full[i]  = ev_sq[i] >> ev_ctrl.k;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else begin
      st_valid <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_valid) begin
      st_ctrl <= ev_ctrl;
      for (int i = 0; i < 6; i++) begin
        st_mean[i] <= mean[i];
        st_sqm[i]  <= sqm_full[i][SQM_W-1:0];
        st_msq[i]  <= msq[i][SQM_W-1:0];
      end
    end
  end

endmodule

### rtl/isc_decide.sv
// ----------------------------------------------------------------------------
// isc_decide
// Motion and orientation checks, bias and position stores, result forming.
// ----------------------------------------------------------------------------
module isc_decide (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             st_valid,
  input  isc_pkg::ev_ctrl_t                st_ctrl,
  input  logic [5:0][15:0]                 st_mean,
  input  logic [5:0][isc_pkg::SQM_W-1:0]   st_sqm,
  input  logic [5:0][isc_pkg::SQM_W-1:0]   st_msq,
  input  logic [isc_pkg::LIMIT_W-1:0]      gyro_var_limit,
  input  logic [isc_pkg::LIMIT_W-1:0]      accel_var_limit,
  input  logic [isc_pkg::ANGLE_W-1:0]      orient_limit,
  input  logic [isc_pkg::ANGLE_W-1:0]      verify_limit,
  output logic                             res_valid,
  output isc_pkg::result_t                 res
);
  import isc_pkg::*;

  logic signed [SQM_W:0] var_d [6];
  logic [5:0]            over;
  logic                  accel_moved;
  logic                  gyro_moved;
  logic [15:0]           pv;
  logic                  up_fail;
  logic                  dn_fail;
  logic signed [16:0]    neg_orient;
  logic                  store_up;
  logic                  store_dn;
  status_t               pos_status;
  logic signed [16:0]    d     [3];
  logic [16:0]           mag   [3];
  logic [15:0]           corr  [3];
  logic [2:0]            high;
  logic signed [16:0]    fsum  [3];
  logic [15:0]           off   [3];
  logic [15:0]           spans [3];
  logic [15:0]           span_sel;
  logic                  all_valid;

  logic [15:0]           bias_store [3];
  logic                  bias_ok;
  logic                  live_verify;
  logic [15:0]           pos_up [3];
  logic [15:0]           pos_dn [3];
  logic [2:0]            up_valid;
  logic [2:0]            dn_valid;

  // variance checks
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      var_d[i] = $signed({1'b0, st_sqm[i]}) - $signed({1'b0, st_msq[i]});
      if (i < 3) begin
        over[i] = !var_d[i][SQM_W] && (var_d[i][SQM_W-1:0] > {1'b0, accel_var_limit});
      end else begin
        over[i] = !var_d[i][SQM_W] && (var_d[i][SQM_W-1:0] > {1'b0, gyro_var_limit});
      end
    end
  end

  assign accel_moved = |over[2:0];
  assign gyro_moved  = |over[5:3];

  // position capture
  always_comb begin
    case (st_ctrl.axis)
      2'd0:    pv = st_mean[0];
      2'd1:    pv = st_mean[1];
      default: pv = st_mean[2];
    endcase
  end

  assign neg_orient = -$signed({2'b00, orient_limit});
  assign up_fail    = $signed(pv) < $signed({1'b0, orient_limit});
  assign dn_fail    = $signed({pv[15], pv}) > neg_orient;
  assign store_up   = !accel_moved && st_ctrl.sign && !up_fail;
  assign store_dn   = !accel_moved && !st_ctrl.sign && !dn_fail;

  always_comb begin
    pos_status = ST_PASS;
    if (accel_moved) begin
      pos_status = ST_MOVED;
    end else if (st_ctrl.sign ? up_fail : dn_fail) begin
      pos_status = ST_ORIENT;
    end
  end

  // verify and fit arithmetic
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i]    = $signed({st_mean[3+i][15], st_mean[3+i]}) -
                $signed({bias_store[i][15], bias_store[i]});
      mag[i]  = d[i][16] ? 17'(-d[i]) : d[i];
      high[i] = mag[i] >= {2'b00, verify_limit};
      if (d[i][16] != d[i][15]) begin
        corr[i] = d[i][16] ? 16'h8000 : 16'h7fff;
      end else begin
        corr[i] = d[i][15:0];
      end
      fsum[i]  = $signed({pos_up[i][15], pos_up[i]}) + $signed({pos_dn[i][15], pos_dn[i]});
      off[i]   = fsum[i][16:1];
      spans[i] = pos_up[i] - pos_dn[i];
    end
  end

  always_comb begin
    case (st_ctrl.axis)
      2'd0:    span_sel = spans[0];
      2'd1:    span_sel = spans[1];
      default: span_sel = spans[2];
    endcase
  end

  assign all_valid = (&up_valid) && (&dn_valid);

  // result
  always_comb begin
    res_valid  = 1'b0;
    res        = '0;
    res.status = ST_PASS;
    if (st_valid) begin
      unique case (st_ctrl.kind)
        EV_BIAS_START: begin
        end
        EV_VERIFY_START: begin
          if (!bias_ok) begin
            res_valid  = 1'b1;
            res.status = ST_NO_BIAS;
          end
        end
        EV_FIT: begin
          res_valid = 1'b1;
          if (!all_valid) begin
            res.status = ST_FIT_INCOMPLETE;
          end else begin
            res.x    = off[0];
            res.y    = off[1];
            res.z    = off[2];
            res.span = span_sel;
          end
        end
        EV_WINDOW_END: begin
          unique case (st_ctrl.mode)
            MODE_BIAS: begin
              res_valid  = 1'b1;
              res.status = gyro_moved ? ST_MOVED : ST_PASS;
              res.x      = st_mean[3];
              res.y      = st_mean[4];
              res.z      = st_mean[5];
            end
            MODE_POS: begin
              res_valid  = 1'b1;
              res.status = pos_status;
              res.x      = st_mean[0];
              res.y      = st_mean[1];
              res.z      = st_mean[2];
            end
            MODE_VERIFY: begin
              res_valid  = live_verify;
              res.status = (high != 3'd0) ? ST_VERIFY_HIGH : ST_PASS;
              res.x      = corr[0];
              res.y      = corr[1];
              res.z      = corr[2];
              res.flags  = high;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // control state of the stores
  always_ff @(posedge clk) begin
    if (rst) begin
      bias_ok     <= 1'b0;
      live_verify <= 1'b0;
      up_valid    <= '0;
      dn_valid    <= '0;
    end else if (st_valid) begin
      case (st_ctrl.kind)
        EV_BIAS_START:   bias_ok <= 1'b0;
        EV_VERIFY_START: live_verify <= bias_ok;
        EV_WINDOW_END: begin
          if (st_ctrl.mode == MODE_BIAS && !gyro_moved) begin
            bias_ok <= 1'b1;
          end
          if (st_ctrl.mode == MODE_POS && store_up) begin
            up_valid[st_ctrl.axis] <= 1'b1;
          end
          if (st_ctrl.mode == MODE_POS && store_dn) begin
            dn_valid[st_ctrl.axis] <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // stored readings
  always_ff @(posedge clk) begin
    if (st_valid && st_ctrl.kind == EV_WINDOW_END) begin
      if (st_ctrl.mode == MODE_BIAS && !gyro_moved) begin
        for (int i = 0; i < 3; i++) begin
          bias_store[i] <= st_mean[3+i];
        end
      end
      if (st_ctrl.mode == MODE_POS && store_up) begin
        pos_up[st_ctrl.axis] <= pv;
      end
      if (st_ctrl.mode == MODE_POS && store_dn) begin
        pos_dn[st_ctrl.axis] <= pv;
      end
    end
  end

endmodule

### rtl/isc_out_fifo.sv
// ----------------------------------------------------------------------------
// isc_out_fifo
// Result queue between the decision stage and the output channel.
// ----------------------------------------------------------------------------
module isc_out_fifo (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  isc_pkg::result_t                 wr_data,
  input  logic                             rd_en,
  output logic                             rd_valid,
  output isc_pkg::result_t                 rd_data,
  output logic [isc_pkg::OUT_CNT_W-1:0]    count
);
  import isc_pkg::*;

  result_t           mem [OUT_DEPTH];
  logic [OUT_AW-1:0] wr_ptr;
  logic [OUT_AW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + OUT_AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + OUT_AW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + OUT_CNT_W'(1);
      end else if (!wr_en && rd_en) begin
        count <= count - OUT_CNT_W'(1);
      end
    end
  end

  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];

endmodule

### rtl/isc_checker.sv
// ----------------------------------------------------------------------------
// isc_checker
// Port-level checks of the calibrator result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module isc_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         status,
  input logic signed [15:0] out_x,
  input logic signed [15:0] out_y,
  input logic signed [15:0] out_z,
  input logic [15:0]        span,
  input logic [2:0]         high_flags
);
  import isc_pkg::*;

  `ASSERT_CLK(a_valid_held, out_valid && out_stall |=> out_valid, "result dropped while stalled")

  `ASSERT_CLK(a_payload_held, out_valid && out_stall |=> $stable(status) && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(span) && $stable(high_flags), "stalled result changed")

  `ASSERT_CLK(a_flags_match, out_valid |-> ((high_flags != 3'd0) == (status == ST_VERIFY_HIGH)), "high flags disagree with status")

  `ASSERT_CLK(a_error_zero, out_valid && (status == ST_NO_BIAS || status == ST_FIT_INCOMPLETE) |-> out_x == 16'sd0 && out_y == 16'sd0 && out_z == 16'sd0 && span == 16'd0, "error result carries data")

  `ASSERT_CLK_NORST(a_reset_empty, rst |=> !out_valid, "result present after reset")

endmodule

bind imu_still_window_calibrator_core isc_checker u_isc_checker (.*);
